// ----- rtl/hex_integer_alu_macros.svh -----
// assertion helpers used by hia_back.sv
`ifndef HEX_INTEGER_ALU_MACROS_SVH
`define HEX_INTEGER_ALU_MACROS_SVH

// condition must never hold outside reset
`define HIA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define HIA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/hia_pkg.sv -----
`default_nettype none
package hia_pkg;

  localparam int unsigned PortW = 64;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4
  } op_e;

  // control that travels with each item down the pipe
  typedef struct packed {
    logic valid;
    logic [2:0] op;
    logic gt;
    logic eq;
    logic range_f;
    logic dz;
  } ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/hia_front.sv -----
`default_nettype none
module hia_front import hia_pkg::*; #(
  parameter int unsigned W = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire logic [2:0]       op_i,
  input  wire logic [PortW-1:0] operand_a_i,
  input  wire logic [PortW-1:0] operand_b_i,
  output ctrl_t                 ctrl_o,
  output logic [W-1:0]          a_o,
  output logic [W-1:0]          b_o,
  output logic [W-1:0]          sh_o,
  output logic [W-1:0]          acc_o,
  output logic [W-1:0]          q_o
);

  logic [W-1:0] a, b;
  logic [W:0]   sum;
  ctrl_t        ctrl_d, ctrl_q;
  logic [W-1:0] sh_d, acc_d, a_q, b_q, sh_q, acc_q;

  assign a   = operand_a_i[W-1:0];
  assign b   = operand_b_i[W-1:0];
  assign sum = {1'b0, a} + {1'b0, b};

  always_comb begin
    ctrl_d.valid   = valid_i;
    ctrl_d.op      = op_i;
    ctrl_d.gt      = a > b;
    ctrl_d.eq      = a == b;
    ctrl_d.range_f = 1'b0;
    ctrl_d.dz      = 1'b0;
    sh_d           = a;
    acc_d          = '0;
    case (op_e'(op_i))
      OP_ADD: begin
        acc_d          = sum[W-1:0];
        ctrl_d.range_f = sum[W];
      end
      OP_SUB: begin
        if (a < b) begin
          ctrl_d.range_f = 1'b1;
        end else begin
          acc_d = a - b;
        end
      end
      OP_MUL: sh_d = b;
      OP_DIV, OP_MOD: ctrl_d.dz = (b == '0);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q   <= a;
      b_q   <= b;
      sh_q  <= sh_d;
      acc_q <= acc_d;
    end
  end

  assign ctrl_o = ctrl_q;
  assign a_o    = a_q;
  assign b_o    = b_q;
  assign sh_o   = sh_q;
  assign acc_o  = acc_q;
  assign q_o    = '0;

endmodule
`default_nettype wire

// ----- rtl/hia_step.sv -----
`default_nettype none
module hia_step import hia_pkg::*; #(
  parameter int unsigned W = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         en_i,
  input  wire ctrl_t        ctrl_i,
  input  wire logic [W-1:0] a_i,
  input  wire logic [W-1:0] b_i,
  input  wire logic [W-1:0] sh_i,
  input  wire logic [W-1:0] acc_i,
  input  wire logic [W-1:0] q_i,
  output ctrl_t             ctrl_o,
  output logic [W-1:0]      a_o,
  output logic [W-1:0]      b_o,
  output logic [W-1:0]      sh_o,
  output logic [W-1:0]      acc_o,
  output logic [W-1:0]      q_o
);

  ctrl_t        ctrl_d, ctrl_q;
  logic [W-1:0] acc_d, q_d, a_q, b_q, sh_q, acc_q, q_q;
  logic [W:0]   prod, rem;
  logic [W+1:0] diff;
  logic         ge;

  // msb-first shift-add for multiply, restoring step for divide
  assign prod = {1'b0, acc_i[W-2:0], 1'b0} + (sh_i[W-1] ? {1'b0, a_i} : '0);
  assign rem  = {acc_i, sh_i[W-1]};
  assign diff = {1'b0, rem} - {2'b00, b_i};
  assign ge   = !diff[W+1];

  always_comb begin
    ctrl_d = ctrl_i;
    acc_d  = acc_i;
    q_d    = q_i;
    case (op_e'(ctrl_i.op))
      OP_MUL: begin
        acc_d          = prod[W-1:0];
        ctrl_d.range_f = ctrl_i.range_f | acc_i[W-1] | prod[W];
      end
      OP_DIV, OP_MOD: begin
        acc_d = ge ? diff[W-1:0] : rem[W-1:0];
        q_d   = {q_i[W-2:0], ge};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      sh_q  <= {sh_i[W-2:0], 1'b0};
      acc_q <= acc_d;
      q_q   <= q_d;
    end
  end

  assign ctrl_o = ctrl_q;
  assign a_o    = a_q;
  assign b_o    = b_q;
  assign sh_o   = sh_q;
  assign acc_o  = acc_q;
  assign q_o    = q_q;

endmodule
`default_nettype wire

// ----- rtl/hia_back.sv -----
`default_nettype none
`include "hex_integer_alu_macros.svh"
module hia_back import hia_pkg::*; #(
  parameter int unsigned W = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         en_i,
  input  wire ctrl_t        ctrl_i,
  input  wire logic [W-1:0] acc_i,
  input  wire logic [W-1:0] q_i,
  output logic              valid_o,
  output logic [PortW-1:0]  result_o,
  output logic              gt_o,
  output logic              eq_o,
  output logic              range_o,
  output logic              dz_o
);

  logic [W-1:0]     res;
  logic             valid_q;
  logic [PortW-1:0] result_q;
  logic             gt_q, eq_q, range_q, dz_q;

  always_comb begin
    case (op_e'(ctrl_i.op))
      OP_ADD, OP_SUB, OP_MUL: res = acc_i;
      OP_DIV:  res = ctrl_i.dz ? '0 : q_i;
      OP_MOD:  res = ctrl_i.dz ? '0 : acc_i;
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      result_q <= PortW'(res);
      gt_q     <= ctrl_i.gt;
      eq_q     <= ctrl_i.eq;
      range_q  <= ctrl_i.range_f;
      dz_q     <= ctrl_i.dz;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;
  assign gt_o     = gt_q;
  assign eq_o     = eq_q;
  assign range_o  = range_q;
  assign dz_o     = dz_q;

  `HIA_ASSERT_NEVER(a_cmp_excl, valid_q && gt_q && eq_q, "greater and equal both set")
  `HIA_ASSERT_NEVER(a_flag_excl, valid_q && range_q && dz_q, "range and zero-divide both set")
  `HIA_ASSERT_IMPL(a_dz_zero, valid_q && dz_q, result_q == '0, "zero divisor gave nonzero result")
  `HIA_ASSERT_IMPL(a_eq_no_range, valid_q && eq_q && range_q, !gt_q, "equal operands with greater")

endmodule
`default_nettype wire

// ----- rtl/hex_integer_alu.sv -----
// channel   | bus          | fields (lowest bit up)
// ----------+--------------+-----------------------------------------------------
// operands  | s_axis_*     | tdata: op[2:0], operand_a[66:3], operand_b[130:67]
// results   | m_axis_*     | tdata: result[63:0], a_greater, operands_equal,
//           |              |        out_of_range, divide_by_zero
//
// the pipe is a setup stage, one shift-add or restoring subtract stage per
// operand bit, and the output register
// one transaction may enter each cycle; the whole pipe holds while the
// output register is full and not taken, so nothing is lost or repeated
// rst_ni clears all valid bits asynchronously; data registers are not reset
`default_nettype none
module hex_integer_alu import hia_pkg::*; #(
  parameter int unsigned DIGITS = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [135:0] s_axis_tdata,  // op, operand_a, operand_b, zero pad
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [71:0]       m_axis_tdata   // result, a_greater, operands_equal,
                                           // out_of_range, divide_by_zero, zero pad
);

  localparam int unsigned W = 4 * DIGITS;

  logic  en;
  ctrl_t        ctrl_s [W+1];
  logic [W-1:0] a_s    [W+1];
  logic [W-1:0] b_s    [W+1];
  logic [W-1:0] sh_s   [W+1];
  logic [W-1:0] acc_s  [W+1];
  logic [W-1:0] q_s    [W+1];

  logic [PortW-1:0] result;
  logic gt, eq, range_f, dz, out_valid;

  assign en            = !out_valid || m_axis_tready;
  assign s_axis_tready = en;

  hia_front #(.W(W)) u_front (
    .clk_i, .rst_ni,
    .en_i        (en),
    .valid_i     (s_axis_tvalid),
    .op_i        (s_axis_tdata[2:0]),
    .operand_a_i (s_axis_tdata[66:3]),
    .operand_b_i (s_axis_tdata[130:67]),
    .ctrl_o      (ctrl_s[0]),
    .a_o         (a_s[0]),
    .b_o         (b_s[0]),
    .sh_o        (sh_s[0]),
    .acc_o       (acc_s[0]),
    .q_o         (q_s[0])
  );

  for (genvar i = 0; i < W; i++) begin : g_step
    hia_step #(.W(W)) u_step (
      .clk_i, .rst_ni,
      .en_i   (en),
      .ctrl_i (ctrl_s[i]),
      .a_i    (a_s[i]),
      .b_i    (b_s[i]),
      .sh_i   (sh_s[i]),
      .acc_i  (acc_s[i]),
      .q_i    (q_s[i]),
      .ctrl_o (ctrl_s[i+1]),
      .a_o    (a_s[i+1]),
      .b_o    (b_s[i+1]),
      .sh_o   (sh_s[i+1]),
      .acc_o  (acc_s[i+1]),
      .q_o    (q_s[i+1])
    );
  end

  hia_back #(.W(W)) u_back (
    .clk_i, .rst_ni,
    .en_i     (en),
    .ctrl_i   (ctrl_s[W]),
    .acc_i    (acc_s[W]),
    .q_i      (q_s[W]),
    .valid_o  (out_valid),
    .result_o (result),
    .gt_o     (gt),
    .eq_o     (eq),
    .range_o  (range_f),
    .dz_o     (dz)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, dz, range_f, eq, gt, result};

endmodule
`default_nettype wire

// ----- sim/hex_integer_alu_tb.sv -----
`default_nettype none
module hex_integer_alu_tb;
  import hia_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumDigits = 16;
  localparam int unsigned Latency = 4 * NumDigits + 2;
  localparam int unsigned NumRandom = 1130;
  localparam int unsigned WatchdogLimit = 20000;
  localparam logic [2:0] OpUnused5 = 3'd5;
  localparam logic [2:0] OpUnused6 = 3'd6;
  localparam logic [2:0] OpUnused7 = 3'd7;
  localparam logic [63:0] Max = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [63:0] value;
    logic        gt;
    logic        eq;
    logic        range_f;
    logic        dz;
  } alu_res_t;

  typedef struct {
    logic [2:0]  op;
    logic [63:0] a;
    logic [63:0] b;
    logic        typed;
    alu_res_t    res;
  } stim_row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [71:0]  m_axis_tdata;

  alu_res_t  pending_results[$];
  stim_row_t dir_rows[$];
  int        errors;
  int        idle_cycles;
  bit        quiet_tail;

  hex_integer_alu #(.DIGITS(NumDigits)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic alu_res_t compute_alu(logic [2:0] op, logic [63:0] a, logic [63:0] b);
    alu_res_t    r;
    logic [64:0] sum;
    logic [127:0] prod;
    r = '0;
    r.gt = a > b;
    r.eq = a == b;
    case (op)
      OP_ADD: begin
        sum = {1'b0, a} + {1'b0, b};
        r.value = sum[63:0];
        r.range_f = sum[64];
      end
      OP_SUB: begin
        if (a < b) r.range_f = 1'b1;
        else r.value = a - b;
      end
      OP_MUL: begin
        prod = {64'd0, a} * {64'd0, b};
        r.value = prod[63:0];
        r.range_f = |prod[127:64];
      end
      OP_DIV: begin
        if (b == 0) r.dz = 1'b1;
        else r.value = a / b;
      end
      OP_MOD: begin
        if (b == 0) r.dz = 1'b1;
        else r.value = a % b;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = v >> $urandom_range(0, 63);
      1: v = v & 64'hFF;
      2: v = Max - v[3:0];
      default: ;
    endcase
    return v;
  endfunction

  task automatic add_row(logic [2:0] op, logic [63:0] a, logic [63:0] b, logic typed,
                         logic [63:0] value = 0, logic gt = 0, logic eq = 0,
                         logic range_f = 0, logic dz = 0);
    stim_row_t row;
    row.op = op;
    row.a = a;
    row.b = b;
    row.typed = typed;
    row.res = '{value, gt, eq, range_f, dz};
    dir_rows.push_back(row);
  endtask

  task automatic send_operands(logic [2:0] op, logic [63:0] a, logic [63:0] b);
    if (!quiet_tail && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'd0, b, a, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // expectation is queued by the monitor at acceptance
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      pending_results.push_back(compute_alu(s_axis_tdata[2:0], s_axis_tdata[66:3],
                                            s_axis_tdata[130:67]));
  end

  always @(posedge clk_i) begin
    alu_res_t exp_r, got_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_r = {m_axis_tdata[63:0], m_axis_tdata[64], m_axis_tdata[65], m_axis_tdata[66],
               m_axis_tdata[67]};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got_r);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got_r.value !== exp_r.value) begin
          $display("%0t: result expected %h actual %h", $time, exp_r.value, got_r.value);
          errors++;
        end
        if (got_r.gt !== exp_r.gt) begin
          $display("%0t: a_greater expected %b actual %b", $time, exp_r.gt, got_r.gt);
          errors++;
        end
        if (got_r.eq !== exp_r.eq) begin
          $display("%0t: operands_equal expected %b actual %b", $time, exp_r.eq, got_r.eq);
          errors++;
        end
        if (got_r.range_f !== exp_r.range_f) begin
          $display("%0t: out_of_range expected %b actual %b", $time, exp_r.range_f,
                   got_r.range_f);
          errors++;
        end
        if (got_r.dz !== exp_r.dz) begin
          $display("%0t: divide_by_zero expected %b actual %b", $time, exp_r.dz, got_r.dz);
          errors++;
        end
      end
    end
  end

  // result-side stalls in bursts
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("** hex_integer_alu: FAILED **");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    logic [2:0] op;
    logic [63:0] a, b;
    errors = 0;
    idle_cycles = 0;
    quiet_tail = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    add_row(OP_ADD, 64'd0, 64'd0, 1, 64'd0, 0, 1, 0, 0);
    add_row(OP_ADD, Max, 64'd1, 1, 64'd0, 1, 0, 1, 0);
    add_row(OP_ADD, Max, Max, 1, Max - 1, 0, 1, 1, 0);
    add_row(OP_ADD, 64'h1234, 64'hFFFF_0000_0000_0000, 0);
    add_row(OP_SUB, 64'd5, 64'd7, 1, 64'd0, 0, 0, 1, 0);
    add_row(OP_SUB, Max, 64'd0, 1, Max, 1, 0, 0, 0);
    add_row(OP_SUB, 64'd0, Max, 1, 64'd0, 0, 0, 1, 0);
    add_row(OP_SUB, 64'h8000_0000_0000_0000, 64'd1, 0);
    add_row(OP_MUL, Max, Max, 1, 64'd1, 0, 1, 1, 0);
    add_row(OP_MUL, Max, 64'd0, 1, 64'd0, 1, 0, 0, 0);
    add_row(OP_MUL, 64'h1_0000_0000, 64'h1_0000_0000, 1, 64'd0, 0, 1, 1, 0);
    add_row(OP_MUL, 64'hFFFF_FFFF, 64'h1_0000_0001, 0);
    add_row(OP_DIV, Max, 64'd0, 1, 64'd0, 1, 0, 0, 1);
    add_row(OP_DIV, Max, 64'd1, 1, Max, 1, 0, 0, 0);
    add_row(OP_DIV, 64'd1, Max, 1, 64'd0, 0, 0, 0, 0);
    add_row(OP_DIV, Max, 64'h10, 0);
    add_row(OP_MOD, 64'd9, 64'd0, 1, 64'd0, 1, 0, 0, 1);
    add_row(OP_MOD, Max, Max, 1, 64'd0, 0, 1, 0, 0);
    add_row(OP_MOD, Max, 64'h8000_0000_0000_0000, 0);
    add_row(OpUnused5, Max, 64'd3, 1, 64'd0, 1, 0, 0, 0);
    add_row(OpUnused6, 64'd0, 64'd0, 1, 64'd0, 0, 1, 0, 0);
    add_row(OpUnused7, 64'd2, Max, 1, 64'd0, 0, 0, 0, 0);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.typed && compute_alu(row.op, row.a, row.b) !== row.res) begin
        $display("%0t: table row %0d expected %h predicted %h", $time, i, row.res,
                 compute_alu(row.op, row.a, row.b));
        errors++;
      end
      send_operands(row.op, row.a, row.b);
    end

    // drain once before random traffic
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);

    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom - 150) quiet_tail = 1'b1;
      op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                        : 3'($urandom_range(0, 4));
      a = rand64();
      case ($urandom_range(0, 9))
        0: b = 64'd0;
        1: b = a;
        default: b = rand64();
      endcase
      send_operands(op, a, b);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (Latency + 10) @(negedge clk_i);
    if (errors == 0)
      $display("** hex_integer_alu: PASSED **");
    else
      $display("** hex_integer_alu: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire

// ----- hex_integer_alu.f -----
+incdir+rtl
rtl/hia_pkg.sv
rtl/hia_front.sv
rtl/hia_step.sv
rtl/hia_back.sv
rtl/hex_integer_alu.sv
sim/hex_integer_alu_tb.sv
